// ----- rtl/gelu_tanh_activation_assert.svh -----
// ----------------------------------------------------------------------------
// GELU tanh activation assertion macros
// Shared concurrent check forms, clocked on clk and idle under reset.
// ----------------------------------------------------------------------------
`ifndef GELU_TANH_ACTIVATION_ASSERT_SVH
`define GELU_TANH_ACTIVATION_ASSERT_SVH

// same-cycle implication
`define GTA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GTA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/gta_pkg.sv -----
// ----------------------------------------------------------------------------
// GELU tanh activation package
// Q4.12 formats, fixed constants, rounding helpers and the tanh table.
// ----------------------------------------------------------------------------
package gta_pkg;

    localparam int DATA_WIDTH   = 16;
    localparam int FRAC_BITS    = 12;
    localparam int TANH_ENTRIES = 64;
    localparam int IDX_W        = $clog2(TANH_ENTRIES);
    localparam int PROD_W       = 2 * DATA_WIDTH;
    localparam int PIPE_DEPTH   = 8;

    typedef logic signed [DATA_WIDTH-1:0] sample_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic [FRAC_BITS:0]           mag_t;
    typedef logic [IDX_W-1:0]             idx_t;
    typedef logic [7:0]                   frac_t;

    typedef struct packed {
        logic [PIPE_DEPTH-1:0] load;
        logic [PIPE_DEPTH-1:0] valid;
    } pipe_ctrl_t;

    localparam sample_t C1_Q     = 16'sd3268;
    localparam sample_t C2_Q     = 16'sd183;
    localparam mag_t    ONE_Q    = 13'd4096;
    localparam sample_t SAT_MAX  = 16'sh7fff;
    localparam sample_t SAT_MIN  = 16'sh8000;
    localparam logic [FRAC_BITS-1:0] HALF_LSB = 12'h800;

    // round product back to Q4.12, ties to even, then clamp
    function automatic sample_t rne_sat(input prod_t p);
        logic signed [PROD_W-FRAC_BITS-1:0] q;
        logic [FRAC_BITS-1:0]               r;
        logic                               up;
        logic signed [PROD_W-FRAC_BITS:0]   qr;
        sample_t                            res;
        q  = p[PROD_W-1:FRAC_BITS];
        r  = p[FRAC_BITS-1:0];
        up = (r > HALF_LSB) || ((r == HALF_LSB) && q[0]);
        qr = {q[PROD_W-FRAC_BITS-1], q} + {{(PROD_W-FRAC_BITS){1'b0}}, up};
        if (qr > 21'sd32767)
            res = SAT_MAX;
        else if (qr < -21'sd32768)
            res = SAT_MIN;
        else
            res = qr[DATA_WIDTH-1:0];
        return res;
    endfunction

    function automatic sample_t sat_add(input sample_t a, input sample_t b);
        logic signed [DATA_WIDTH:0] s;
        sample_t                    res;
        s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
        if (s[DATA_WIDTH] != s[DATA_WIDTH-1])
            res = s[DATA_WIDTH] ? SAT_MIN : SAT_MAX;
        else
            res = s[DATA_WIDTH-1:0];
        return res;
    endfunction

    // tanh(4k/64) in Q.12
    function automatic mag_t tanh_rom(input idx_t k);
        mag_t v;
        unique case (k)
            6'd0:  v = 13'd0;
            6'd1:  v = 13'd256;
            6'd2:  v = 13'd509;
            6'd3:  v = 13'd759;
            6'd4:  v = 13'd1003;
            6'd5:  v = 13'd1240;
            6'd6:  v = 13'd1468;
            6'd7:  v = 13'd1686;
            6'd8:  v = 13'd1893;
            6'd9:  v = 13'd2088;
            6'd10: v = 13'd2272;
            6'd11: v = 13'd2443;
            6'd12: v = 13'd2602;
            6'd13: v = 13'd2748;
            6'd14: v = 13'd2883;
            6'd15: v = 13'd3007;
            6'd16: v = 13'd3119;
            6'd17: v = 13'd3222;
            6'd18: v = 13'd3315;
            6'd19: v = 13'd3399;
            6'd20: v = 13'd3475;
            6'd21: v = 13'd3543;
            6'd22: v = 13'd3604;
            6'd23: v = 13'd3659;
            6'd24: v = 13'd3707;
            6'd25: v = 13'd3751;
            6'd26: v = 13'd3790;
            6'd27: v = 13'd3825;
            6'd28: v = 13'd3856;
            6'd29: v = 13'd3883;
            6'd30: v = 13'd3908;
            6'd31: v = 13'd3929;
            6'd32: v = 13'd3949;
            6'd33: v = 13'd3966;
            6'd34: v = 13'd3981;
            6'd35: v = 13'd3994;
            6'd36: v = 13'd4006;
            6'd37: v = 13'd4016;
            6'd38: v = 13'd4026;
            6'd39: v = 13'd4034;
            6'd40: v = 13'd4041;
            6'd41: v = 13'd4048;
            6'd42: v = 13'd4053;
            6'd43: v = 13'd4058;
            6'd44: v = 13'd4063;
            6'd45: v = 13'd4067;
            6'd46: v = 13'd4070;
            6'd47: v = 13'd4073;
            6'd48: v = 13'd4076;
            6'd49: v = 13'd4078;
            6'd50: v = 13'd4080;
            6'd51: v = 13'd4082;
            6'd52: v = 13'd4084;
            6'd53: v = 13'd4085;
            6'd54: v = 13'd4086;
            6'd55: v = 13'd4088;
            6'd56: v = 13'd4089;
            6'd57: v = 13'd4089;
            6'd58: v = 13'd4090;
            6'd59: v = 13'd4091;
            6'd60: v = 13'd4091;
            6'd61: v = 13'd4092;
            6'd62: v = 13'd4092;
            6'd63: v = 13'd4093;
            default: v = 13'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/gta_pipe_ctrl.sv -----
// ----------------------------------------------------------------------------
// GELU tanh activation pipeline control
// Per-stage valid bits and load enables; bubbles collapse under back-pressure.
// ----------------------------------------------------------------------------
`include "gelu_tanh_activation_assert.svh"

module gta_pipe_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                out_ready,
    output gta_pkg::pipe_ctrl_t ctrl
);
    import gta_pkg::*;

    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] valid_next;
    logic [PIPE_DEPTH:0]   rdy;
    logic [PIPE_DEPTH-1:0] prev;

    always_comb
    begin
        rdy[PIPE_DEPTH] = out_ready;
        for (int i = PIPE_DEPTH - 1; i >= 0; i--)
        begin
            rdy[i] = ~valid_reg[i] | rdy[i+1];
        end
        prev = {valid_reg[PIPE_DEPTH-2:0], in_valid};
        for (int i = 0; i < PIPE_DEPTH; i++)
        begin
            valid_next[i] = rdy[i] ? prev[i] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign in_ready   = rdy[0];
    assign ctrl.load  = rdy[PIPE_DEPTH-1:0] & prev;
    assign ctrl.valid = valid_reg;

    `GTA_ASSERT_NOW(a_full_when_blocked, !in_ready, &valid_reg, "input blocked with a bubble")
    `GTA_ASSERT_NEXT(a_entry_valid, in_valid && in_ready, valid_reg[0], "transaction not captured")
    `GTA_ASSERT_NEXT(a_item_count, 1'b1,
        $countones(valid_reg) == $past($countones(valid_reg))
            + $past(in_valid && in_ready) - $past(valid_reg[PIPE_DEPTH-1] && out_ready),
        "item lost or duplicated")

endmodule

// ----- rtl/gelu_tanh_activation.sv -----
// ----------------------------------------------------------------------------
// GELU tanh activation
// y = 0.5*x*(1+tanh(0.79788456*(x+0.044715*x^3))) on signed Q4.12 samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries x_sample; output channel
//   out_valid/out_ready carries y_sample. A transaction completes on a rising
//   edge with valid and ready both high.
//   Eight register stages: x*x, x*x2, x3*c2, (x+b)*c1, tanh table read,
//   interpolation with half-scaling, x*h, final rounding. Throughput is one
//   sample per cycle while the receiver holds out_ready high.
//   Reset clears all stage valid bits; the pipeline is empty and in_ready high.
//   When the receiver stalls the last stage holds its result; earlier stages
//   keep advancing into empty slots, so in_ready drops only once all eight
//   stages hold a sample.
//   tanh comes from a 64-point table over [0,4) with linear interpolation,
//   odd symmetry and clamping to +-1 beyond 4.
// ----------------------------------------------------------------------------
module gelu_tanh_activation (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  gta_pkg::sample_t x_sample,
    output logic             out_valid,
    input  logic             out_ready,
    output gta_pkg::sample_t y_sample
);
    import gta_pkg::*;

    pipe_ctrl_t ctrl;

    sample_t x0_reg, x1_reg, x2_reg, x3_reg, x4_reg, x5_reg;
    prod_t   p0_reg, p1_reg, p2_reg, p3_reg, p6_reg;
    prod_t   p0_next, p1_next, p2_next, p3_next, p6_next;
    logic    neg4_reg, big4_reg, neg4_next, big4_next;
    mag_t    r0_reg, r1_reg, r0_next, r1_next;
    frac_t   frac_reg, frac_next;
    mag_t    h5_reg, h5_next;
    sample_t y_reg, y_next;

    sample_t          s3;
    sample_t          u4;
    logic [15:0]      a4;
    idx_t             idx4;
    mag_t             diff5;
    logic [20:0]      ip5;
    mag_t             q5;
    logic             up5;
    mag_t             tmag5;
    logic [13:0]      pp5;

    gta_pipe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_ready(out_ready),
        .ctrl     (ctrl)
    );

    always_comb
    begin
        p0_next = prod_t'(x_sample) * prod_t'(x_sample);
        p1_next = prod_t'(x0_reg) * prod_t'(rne_sat(p0_reg));
        p2_next = prod_t'(rne_sat(p1_reg)) * prod_t'(C2_Q);

        s3      = sat_add(x2_reg, rne_sat(p2_reg));
        p3_next = prod_t'(s3) * prod_t'(C1_Q);

        // fold to magnitude, split into table index and fraction
        u4        = rne_sat(p3_reg);
        a4        = u4[DATA_WIDTH-1] ? (16'd0 - 16'(u4)) : 16'(u4);
        neg4_next = u4[DATA_WIDTH-1];
        big4_next = |a4[15:14];
        idx4      = a4[13:8];
        frac_next = a4[7:0];
        r0_next   = tanh_rom(idx4);
        r1_next   = (idx4 == '1) ? ONE_Q : tanh_rom(idx_t'(idx4 + 1'b1));

        // interpolate, apply sign, form h = (1 + t) / 2
        diff5 = r1_reg - r0_reg;
        ip5   = 21'(diff5) * 21'(frac_reg);
        q5    = ip5[20:8];
        up5   = (ip5[7:0] > 8'h80) || ((ip5[7:0] == 8'h80) && q5[0]);
        tmag5 = big4_reg ? ONE_Q : mag_t'(r0_reg + q5 + mag_t'(up5));
        pp5   = neg4_reg ? (14'(ONE_Q) - 14'(tmag5)) : (14'(ONE_Q) + 14'(tmag5));
        h5_next = mag_t'(pp5[13:1] + mag_t'(pp5[0] & pp5[1]));

        p6_next = prod_t'(x5_reg) * prod_t'(sample_t'({3'b000, h5_reg}));
        y_next  = rne_sat(p6_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            x0_reg <= x_sample;
            p0_reg <= p0_next;
        end
        if (ctrl.load[1])
        begin
            x1_reg <= x0_reg;
            p1_reg <= p1_next;
        end
        if (ctrl.load[2])
        begin
            x2_reg <= x1_reg;
            p2_reg <= p2_next;
        end
        if (ctrl.load[3])
        begin
            x3_reg <= x2_reg;
            p3_reg <= p3_next;
        end
        if (ctrl.load[4])
        begin
            x4_reg   <= x3_reg;
            neg4_reg <= neg4_next;
            big4_reg <= big4_next;
            frac_reg <= frac_next;
            r0_reg   <= r0_next;
            r1_reg   <= r1_next;
        end
        if (ctrl.load[5])
        begin
            x5_reg <= x4_reg;
            h5_reg <= h5_next;
        end
        if (ctrl.load[6])
        begin
            p6_reg <= p6_next;
        end
        if (ctrl.load[7])
        begin
            y_reg <= y_next;
        end
    end

    assign out_valid = ctrl.valid[PIPE_DEPTH-1];
    assign y_sample  = y_reg;

endmodule
